/* rtl/wpp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpp_pkg
// Shared types, constants and helpers for the WAV PCM stream parser.
// ----------------------------------------------------------------------------
package wpp_pkg;

  // Parse phases
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_DATA,
    PH_DONE,
    PH_ERROR
  } wpp_phase_t;

  // Canonical header layout (byte offsets)
  localparam int unsigned HDR_LEN   = 44;
  localparam int unsigned RATE_POS  = 24;
  localparam int unsigned DEPTH_POS = 34;
  localparam int unsigned SIZE_POS  = 40;

  localparam int unsigned MAX_BYTES_PER_SAMPLE = 3;

  // Result status codes
  localparam logic STATUS_SAMPLE    = 1'b0;
  localparam logic STATUS_BAD_DEPTH = 1'b1;

  // One input byte as held in the input register
  typedef struct packed {
    logic [7:0] byte_value;
    logic       file_start;
  } wpp_item_t;

  // One result as held in the output register
  typedef struct packed {
    logic        status;
    logic [23:0] sample;
    logic [31:0] sample_index;
    logic        last;
    logic [31:0] sample_rate;
    logic [15:0] bits_per_sample;
  } wpp_result_t;

  // Depth is valid when it is 8*k, k in 1..MAX_BYTES_PER_SAMPLE
  function automatic logic depth_ok(input logic [15:0] d);
    logic [12:0] k;
    k = d[15:3];
    return (d[2:0] == 3'd0) && (k >= 13'd1) && (k <= 13'(MAX_BYTES_PER_SAMPLE));
  endfunction

endpackage

/* rtl/wpp_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpp_in_stage
// Input register: holds one accepted byte until the parse stage takes it.
// ----------------------------------------------------------------------------
module wpp_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  wpp_pkg::wpp_item_t item_in,
  input  logic              advance,
  output logic              item_valid,
  output wpp_pkg::wpp_item_t item_out
);

  logic               valid_r;
  logic               valid_nxt;
  wpp_pkg::wpp_item_t item_r;

  // Ready while empty, and refill whenever the held item moves on this cycle
  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_in;
    end
  end

  assign item_valid = valid_r;
  assign item_out   = item_r;

endmodule

/* rtl/wpp_parse.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpp_parse
// Parse state, header capture, sample assembly and the result register.
// ----------------------------------------------------------------------------
module wpp_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  wpp_pkg::wpp_item_t   item,
  output logic                 advance,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wpp_pkg::wpp_result_t result
);

  wpp_pkg::wpp_phase_t phase_r, phase_nxt, phase_base;
  logic [5:0]  pos_r, pos_nxt, pos_base;
  logic [31:0] rate_r, rate_nxt, rate_base;
  logic [15:0] depth_r, depth_nxt, depth_base;
  logic [31:0] size_r, size_nxt, size_base;
  logic [31:0] left_r, left_nxt;
  logic [15:0] part_r, part_nxt;
  logic [1:0]  bis_r, bis_nxt;
  logic [31:0] idx_r, idx_nxt;

  logic                 out_valid_r;
  wpp_pkg::wpp_result_t res_r;
  wpp_pkg::wpp_result_t res_nxt;
  logic                 emit;
  logic                 take;

  logic [7:0]  b;
  logic [5:0]  rate_off, depth_off, size_off;
  logic [31:0] size_full;
  logic [1:0]  nbytes;
  logic [2:0]  bis_inc;
  logic [31:0] two_n;
  logic        hdr_end;
  logic        hdr_good;
  logic        data_done;
  logic        data_last;

  assign advance = !out_valid_r || out_ready;
  assign take    = item_valid && advance;
  assign b       = item.byte_value;

  // A file start clears the parse before the byte is used
  always_comb begin
    if (item.file_start) begin
      phase_base = wpp_pkg::PH_HEADER;
      pos_base   = 6'd0;
      rate_base  = 32'd0;
      depth_base = 16'd0;
      size_base  = 32'd0;
    end else begin
      phase_base = phase_r;
      pos_base   = pos_r;
      rate_base  = rate_r;
      depth_base = depth_r;
      size_base  = size_r;
    end
  end

  assign rate_off  = pos_base - 6'(wpp_pkg::RATE_POS);
  assign depth_off = pos_base - 6'(wpp_pkg::DEPTH_POS);
  assign size_off  = pos_base - 6'(wpp_pkg::SIZE_POS);
  assign size_full = {b, size_base[23:0]};
  assign hdr_end   = (pos_base == 6'(wpp_pkg::HDR_LEN - 1));
  assign hdr_good  = wpp_pkg::depth_ok(depth_base);

  // Valid depths are 8, 16, 24: bytes per sample sit in bits 4:3
  assign nbytes    = depth_r[4:3];
  assign bis_inc   = {1'b0, bis_r} + 3'd1;
  assign data_done = (bis_inc >= {1'b0, nbytes});
  assign two_n     = {29'd0, nbytes, 1'b0};
  // Last sample when fewer than two samples' worth of bytes remain
  assign data_last = (left_r < two_n);

  // Next phase
  always_comb begin
    phase_nxt = phase_base;
    unique case (phase_base)
      wpp_pkg::PH_HEADER: begin
        if (hdr_end) begin
          if (!hdr_good) begin
            phase_nxt = wpp_pkg::PH_ERROR;
          end else if (size_full < {30'd0, depth_base[4:3]}) begin
            phase_nxt = wpp_pkg::PH_DONE;
          end else begin
            phase_nxt = wpp_pkg::PH_DATA;
          end
        end
      end
      wpp_pkg::PH_DATA: begin
        if (data_done && data_last) begin
          phase_nxt = wpp_pkg::PH_DONE;
        end
      end
      wpp_pkg::PH_DONE:  phase_nxt = wpp_pkg::PH_DONE;
      wpp_pkg::PH_ERROR: phase_nxt = wpp_pkg::PH_ERROR;
      default:           phase_nxt = wpp_pkg::PH_HEADER;
    endcase
  end

  // Datapath and result
  always_comb begin
    pos_nxt   = pos_base;
    rate_nxt  = rate_base;
    depth_nxt = depth_base;
    size_nxt  = size_base;
    left_nxt  = left_r;
    part_nxt  = part_r;
    bis_nxt   = bis_r;
    idx_nxt   = idx_r;
    emit      = 1'b0;
    res_nxt   = res_r;
    unique case (phase_base)
      wpp_pkg::PH_HEADER: begin
        if (pos_base >= 6'(wpp_pkg::RATE_POS) && pos_base <= 6'(wpp_pkg::RATE_POS + 3)) begin
          rate_nxt[{rate_off[1:0], 3'b000} +: 8] = b;
        end else if (pos_base >= 6'(wpp_pkg::DEPTH_POS) &&
                     pos_base <= 6'(wpp_pkg::DEPTH_POS + 1)) begin
          depth_nxt[{depth_off[0], 3'b000} +: 8] = b;
        end else if (pos_base >= 6'(wpp_pkg::SIZE_POS) &&
                     pos_base <= 6'(wpp_pkg::SIZE_POS + 3)) begin
          size_nxt[{size_off[1:0], 3'b000} +: 8] = b;
        end
        if (hdr_end) begin
          pos_nxt = 6'd0;
          if (!hdr_good) begin
            emit                    = 1'b1;
            res_nxt.status          = wpp_pkg::STATUS_BAD_DEPTH;
            res_nxt.sample          = 24'd0;
            res_nxt.sample_index    = 32'd0;
            res_nxt.last            = 1'b0;
            res_nxt.sample_rate     = rate_nxt;
            res_nxt.bits_per_sample = depth_nxt;
          end else begin
            left_nxt = size_full;
            part_nxt = 16'd0;
            bis_nxt  = 2'd0;
            idx_nxt  = 32'd0;
          end
        end else begin
          pos_nxt = pos_base + 6'd1;
        end
      end
      wpp_pkg::PH_DATA: begin
        if (!data_done) begin
          part_nxt[{bis_r[0], 3'b000} +: 8] = b;
          bis_nxt = bis_inc[1:0];
        end else begin
          emit                 = 1'b1;
          res_nxt.status       = wpp_pkg::STATUS_SAMPLE;
          case (nbytes)
            2'd1:    res_nxt.sample = {{16{b[7]}}, b};
            2'd2:    res_nxt.sample = {{8{b[7]}}, b, part_r[7:0]};
            default: res_nxt.sample = {b, part_r};
          endcase
          res_nxt.sample_index    = idx_r;
          res_nxt.last            = data_last;
          res_nxt.sample_rate     = rate_r;
          res_nxt.bits_per_sample = depth_r;
          idx_nxt  = idx_r + 32'd1;
          left_nxt = left_r - {30'd0, nbytes};
          part_nxt = 16'd0;
          bis_nxt  = 2'd0;
        end
      end
      wpp_pkg::PH_DONE:  ;
      wpp_pkg::PH_ERROR: ;
      default:           ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= wpp_pkg::PH_HEADER;
      pos_r       <= 6'd0;
      rate_r      <= 32'd0;
      depth_r     <= 16'd0;
      size_r      <= 32'd0;
      left_r      <= 32'd0;
      part_r      <= 16'd0;
      bis_r       <= 2'd0;
      idx_r       <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        rate_r  <= rate_nxt;
        depth_r <= depth_nxt;
        size_r  <= size_nxt;
        left_r  <= left_nxt;
        part_r  <= part_nxt;
        bis_r   <= bis_nxt;
        idx_r   <= idx_nxt;
      end
      if (advance) begin
        out_valid_r <= take && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = res_r;

endmodule

/* rtl/wav_pcm_stream_parser_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_pcm_stream_parser_core
// Byte-stream WAV parser: captures header fields and emits PCM samples.
// ----------------------------------------------------------------------------
// The block takes one byte per transfer and accepts a new byte every cycle
// as long as the output side keeps up. A byte passes from an input register
// through one stage of parse logic into the output register. While a result
// waits on the output, the parse stage holds; the input register takes at
// most one more byte, then in_tready drops until the waiting result
// transfers.
// Bytes follow the canonical 44-byte header: the sample rate (bytes 24-27),
// bits per sample (34-35) and data size (40-43) are captured little-endian.
// Chunk IDs are not checked. A byte with in_tuser set starts a new file and
// is header byte 0; after reset the first byte is also header byte 0. After
// the header, each sample is built from 1, 2 or 3 little-endian bytes,
// sign-extended to 24 bits (8-bit data is treated as signed too) and sent
// with its index; out_tlast marks the final sample of the data chunk, which
// holds as many samples as whole ones fit in its data size. A depth other
// than 8, 16 or 24 gives one result with out_tuser set and zero sample, index
// and last. After the last sample, an empty data chunk or an error, drop
// bytes until the next file start. Every result carries the captured rate
// and depth.
// ----------------------------------------------------------------------------
module wav_pcm_stream_parser_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] byte_value
  input  logic         in_tuser,   // [0] file_start
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // [23:0] sample, [55:24] sample_index,
                                   // [87:56] sample_rate,
                                   // [103:88] bits_per_sample
  output logic         out_tuser,  // [0] status
  output logic         out_tlast   // last sample of the data chunk
);

  wpp_pkg::wpp_item_t   item_in;
  wpp_pkg::wpp_item_t   item;
  wpp_pkg::wpp_result_t result;
  logic                 item_valid;
  logic                 advance;

  assign item_in.byte_value = in_tdata;
  assign item_in.file_start = in_tuser;

  // Input register: hold the byte until the parse stage can advance
  wpp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .item_in    (item_in),
    .advance    (advance),
    .item_valid (item_valid),
    .item_out   (item)
  );

  // Parse stage plus output register
  wpp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .result     (result)
  );

  assign out_tdata = {result.bits_per_sample, result.sample_rate,
                      result.sample_index, result.sample};
  assign out_tuser = result.status;
  assign out_tlast = result.last;

endmodule

/* test/tb_wav_pcm_stream_parser_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wav_pcm_stream_parser_core
// Self-checking bench for the WAV PCM byte-stream parser.
// ----------------------------------------------------------------------------
// Feeds whole files byte by byte: a short list of hand-built files (signed
// extremes, bad depths, empty data chunk, restarts inside header and data),
// then random files, mostly well formed, some with truncated headers, missing
// start marks or odd depths. A parse model in the bench tracks each accepted
// byte and queues the samples it should produce; every output transfer is
// checked field by field against the oldest queued sample. Sender gaps and
// receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------
module tb_wav_pcm_stream_parser_core;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned PHASE_BYTES  = 40;
  localparam int unsigned NUM_DIR_ROWS = 13;

  // One file to send: header fields, how much of the header and data to send
  typedef struct packed {
    logic                 mark;       // start mark on the first byte
    logic [5:0]           hdr_bytes;  // header bytes sent (44 = whole header)
    logic [31:0]          rate;
    logic [15:0]          depth;
    logic [31:0]          size;
    logic [7:0]           n_data;     // data bytes sent after the header
    logic [23:0]          word;       // data byte i is word byte (i mod 3)
    logic                 typed;      // the one result is given below
    wpp_pkg::wpp_result_t want;
  } wav_file_t;

  localparam wav_file_t DIR_ROWS [NUM_DIR_ROWS] = '{
    // no start mark after reset; 8-bit signed 0, +127, -128
    '{1'b0, 6'd44, 32'd8000, 16'd8, 32'd3, 8'd3, 24'h807F00, 1'b0, '0},
    // most negative 24-bit sample
    '{1'b1, 6'd44, 32'd48000, 16'd24, 32'd3, 8'd3, 24'h800000, 1'b1,
      '{wpp_pkg::STATUS_SAMPLE, 24'h800000, 32'd0, 1'b1, 32'd48000, 16'd24}},
    // most positive 24-bit sample
    '{1'b1, 6'd44, 32'd96000, 16'd24, 32'd3, 8'd3, 24'h7FFFFF, 1'b1,
      '{wpp_pkg::STATUS_SAMPLE, 24'h7FFFFF, 32'd0, 1'b1, 32'd96000, 16'd24}},
    // 16-bit all ones
    '{1'b1, 6'd44, 32'd44100, 16'd16, 32'd6, 8'd6, 24'hFFFFFF, 1'b0, '0},
    // depth not a whole byte count; data after it dropped
    '{1'b1, 6'd44, 32'd22050, 16'd12, 32'd100, 8'd4, 24'h000000, 1'b1,
      '{wpp_pkg::STATUS_BAD_DEPTH, 24'd0, 32'd0, 1'b0, 32'd22050, 16'd12}},
    // zero depth, zero rate
    '{1'b1, 6'd44, 32'd0, 16'd0, 32'd0, 8'd2, 24'h123456, 1'b1,
      '{wpp_pkg::STATUS_BAD_DEPTH, 24'd0, 32'd0, 1'b0, 32'd0, 16'd0}},
    // all header fields at their maximum
    '{1'b1, 6'd44, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 8'd0, 24'h0, 1'b1,
      '{wpp_pkg::STATUS_BAD_DEPTH, 24'd0, 32'd0, 1'b0, 32'hFFFFFFFF, 16'hFFFF}},
    // whole bytes but too deep
    '{1'b1, 6'd44, 32'd11025, 16'd32, 32'd8, 8'd4, 24'hABCDEF, 1'b1,
      '{wpp_pkg::STATUS_BAD_DEPTH, 24'd0, 32'd0, 1'b0, 32'd11025, 16'd32}},
    // data size smaller than one sample: empty chunk
    '{1'b1, 6'd44, 32'd16000, 16'd16, 32'd1, 8'd3, 24'h7F8001, 1'b0, '0},
    // two 24-bit samples, trailing partial sample and extra bytes
    '{1'b1, 6'd44, 32'd8000, 16'd24, 32'd7, 8'd8, 24'h123456, 1'b0, '0},
    // header cut short, restarted by the next file
    '{1'b1, 6'd20, 32'd1, 16'd8, 32'd1, 8'd0, 24'h0, 1'b0, '0},
    // huge data size, cut off mid-stream by the next file
    '{1'b1, 6'd44, 32'd12345, 16'd8, 32'hFFFFFFFF, 8'd5, 24'hA55A01, 1'b0, '0},
    // one 16-bit sample, then bytes past the end
    '{1'b1, 6'd44, 32'd0, 16'd16, 32'd3, 8'd5, 24'h008001, 1'b0, '0}
  };

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'd0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;

  wav_pcm_stream_parser_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Parse model state
  wpp_pkg::wpp_phase_t parse_phase;
  int unsigned  hdr_pos;
  logic [31:0]  cap_rate;
  logic [15:0]  cap_depth;
  logic [31:0]  cap_size;
  logic [31:0]  samples_left;
  logic [23:0]  partial;
  logic [1:0]   byte_cnt;
  logic [31:0]  next_idx;

  wpp_pkg::wpp_result_t pending_samples [$];
  wpp_pkg::wpp_result_t typed_sample;
  bit           typed_armed = 1'b0;
  int unsigned  mismatch_cnt = 0;
  int unsigned  cycle_cnt = 0;
  int unsigned  idle_pct = 0;
  int unsigned  stall_pct = 0;

  function automatic void clear_parse();
    parse_phase  = wpp_pkg::PH_HEADER;
    hdr_pos      = 0;
    cap_rate     = '0;
    cap_depth    = '0;
    cap_size     = '0;
    samples_left = '0;
    partial      = '0;
    byte_cnt     = '0;
    next_idx     = '0;
  endfunction

  // Advance the parse by one byte; return 1 when a result is due
  function automatic bit parse_byte(input logic [7:0] b, input logic st,
                                    output wpp_pkg::wpp_result_t r);
    int unsigned p;
    int unsigned nb;
    logic [23:0] v;
    r = '0;
    if (st)
      clear_parse();
    if (parse_phase == wpp_pkg::PH_HEADER) begin
      p = hdr_pos;
      if (p >= wpp_pkg::RATE_POS && p < wpp_pkg::RATE_POS + 4)
        cap_rate[8*(p-wpp_pkg::RATE_POS) +: 8] = b;
      else if (p >= wpp_pkg::DEPTH_POS && p < wpp_pkg::DEPTH_POS + 2)
        cap_depth[8*(p-wpp_pkg::DEPTH_POS) +: 8] = b;
      else if (p >= wpp_pkg::SIZE_POS && p < wpp_pkg::SIZE_POS + 4)
        cap_size[8*(p-wpp_pkg::SIZE_POS) +: 8] = b;
      if (p + 1 < wpp_pkg::HDR_LEN) begin
        hdr_pos = p + 1;
        return 1'b0;
      end
      hdr_pos = 0;
      nb = cap_depth / 8;
      if (cap_depth % 8 != 0 || nb == 0 || nb > wpp_pkg::MAX_BYTES_PER_SAMPLE) begin
        parse_phase       = wpp_pkg::PH_ERROR;
        r.status          = wpp_pkg::STATUS_BAD_DEPTH;
        r.sample_rate     = cap_rate;
        r.bits_per_sample = cap_depth;
        return 1'b1;
      end
      samples_left = cap_size / nb;
      partial      = '0;
      byte_cnt     = '0;
      next_idx     = '0;
      parse_phase  = (samples_left == 0) ? wpp_pkg::PH_DONE : wpp_pkg::PH_DATA;
      return 1'b0;
    end
    if (parse_phase == wpp_pkg::PH_DATA) begin
      nb = cap_depth / 8;
      partial[8*byte_cnt +: 8] = b;
      if (byte_cnt + 1 < nb) begin
        byte_cnt = byte_cnt + 2'd1;
        return 1'b0;
      end
      // sign-extend from the sample depth to 24 bits
      v = partial;
      if (nb == 1)
        v = {{16{v[7]}}, v[7:0]};
      else if (nb == 2)
        v = {{8{v[15]}}, v[15:0]};
      r.status          = wpp_pkg::STATUS_SAMPLE;
      r.sample          = v;
      r.sample_index    = next_idx;
      r.last            = (samples_left == 1);
      r.sample_rate     = cap_rate;
      r.bits_per_sample = cap_depth;
      next_idx     = next_idx + 1;
      samples_left = samples_left - 1;
      partial      = '0;
      byte_cnt     = '0;
      if (samples_left == 0)
        parse_phase = wpp_pkg::PH_DONE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Hold one byte on the bus until it transfers, then update the model
  task automatic send_byte(input logic [7:0] b, input logic st);
    wpp_pkg::wpp_result_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= st;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    if (parse_byte(b, st, r)) begin
      if (typed_armed) begin
        pending_samples.push_back(typed_sample);
        typed_armed = 1'b0;
      end else begin
        pending_samples.push_back(r);
      end
    end
  endtask

  task automatic send_file(input wav_file_t f, input bit rand_data);
    logic [7:0] b;
    if (f.typed) begin
      typed_sample = f.want;
      typed_armed  = 1'b1;
    end
    for (int i = 0; i < int'(f.hdr_bytes); i++) begin
      b = 8'($urandom);
      if (i >= wpp_pkg::RATE_POS && i < wpp_pkg::RATE_POS + 4)
        b = f.rate[8*(i-wpp_pkg::RATE_POS) +: 8];
      else if (i >= wpp_pkg::DEPTH_POS && i < wpp_pkg::DEPTH_POS + 2)
        b = f.depth[8*(i-wpp_pkg::DEPTH_POS) +: 8];
      else if (i >= wpp_pkg::SIZE_POS && i < wpp_pkg::SIZE_POS + 4)
        b = f.size[8*(i-wpp_pkg::SIZE_POS) +: 8];
      send_byte(b, f.mark && i == 0);
    end
    for (int i = 0; i < int'(f.n_data); i++) begin
      b = rand_data ? 8'($urandom) : f.word[8*(i%3) +: 8];
      send_byte(b, 1'b0);
    end
  endtask

  // Random files: mostly valid depths and small data chunks
  task automatic send_random_files(input int unsigned n_bytes);
    wav_file_t   f;
    int unsigned sent;
    int unsigned nb;
    int unsigned nsamp;
    int unsigned pick;
    sent = 0;
    while (sent < n_bytes) begin
      f = '0;
      f.mark      = ($urandom_range(9) != 0);
      f.hdr_bytes = ($urandom_range(9) == 0) ? 6'($urandom_range(1, 43)) :
                    6'(wpp_pkg::HDR_LEN);
      f.rate      = $urandom;
      pick = $urandom_range(9);
      if (pick < 8)
        f.depth = 16'(8 * (pick % 3 + 1));
      else if (pick == 8)
        f.depth = 16'($urandom);
      else
        f.depth = 16'(8 * $urandom_range(0, 5));
      nb = (f.depth % 8 == 0 && f.depth / 8 >= 1 &&
            f.depth / 8 <= wpp_pkg::MAX_BYTES_PER_SAMPLE) ? f.depth / 8 : 1;
      nsamp = $urandom_range(0, 24);
      if ($urandom_range(19) == 0) begin
        f.size   = 32'hFFFFFFFF;
        f.n_data = 8'($urandom_range(0, 40));
      end else begin
        f.size   = nsamp * nb + $urandom_range(0, nb - 1);
        f.n_data = ($urandom_range(5) == 0) ? 8'($urandom_range(0, nsamp * nb)) :
                   8'(nsamp * nb + $urandom_range(0, 4));
      end
      send_file(f, 1'b1);
      sent += f.hdr_bytes + f.n_data;
    end
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0)
      @(posedge clk);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Result side: random stalls, compare each transfer
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    wpp_pkg::wpp_result_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_samples.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected result, expected none, actual status %0b data %h last %0b",
                 $time, out_tuser, out_tdata, out_tlast);
      end else begin
        w = pending_samples.pop_front();
        check_field("status", 32'(w.status), 32'(out_tuser));
        check_field("sample", 32'(w.sample), 32'(out_tdata[23:0]));
        check_field("sample_index", w.sample_index, out_tdata[55:24]);
        check_field("last", 32'(w.last), 32'(out_tlast));
        check_field("sample_rate", w.sample_rate, out_tdata[87:56]);
        check_field("bits_per_sample", 32'(w.bits_per_sample), 32'(out_tdata[103:88]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    clear_parse();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // hand-built files, no gaps
    for (int k = 0; k < NUM_DIR_ROWS; k++)
      send_file(DIR_ROWS[k], 1'b0);
    // hold the input until every queued sample is out
    in_tvalid <= 1'b0;
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 87; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 87; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      send_random_files(PHASE_BYTES);
    end
    in_tvalid <= 1'b0;
    stall_pct = 0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0 && pending_samples.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* filelist.f */
rtl/wpp_pkg.sv
rtl/wpp_in_stage.sv
rtl/wpp_parse.sv
rtl/wav_pcm_stream_parser_core.sv
test/tb_wav_pcm_stream_parser_core.sv
